[hw/rtl/assert_macros.svh]
// assertion macros for the alu
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[hw/rtl/sia_pkg.sv]
// shared types and constants for the signed integer alu
package sia_pkg;
   localparam int DefaultDataWidth = 32;
   localparam int OpWidth = 4;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_NEG = 4'd2, OP_MUL = 4'd3,
      OP_DIV = 4'd4, OP_MOD = 4'd5, OP_POW = 4'd6, OP_LT = 4'd7,
      OP_LE = 4'd8, OP_EQ = 4'd9, OP_NE = 4'd10, OP_GE = 4'd11,
      OP_GT = 4'd12, OP_CAT = 4'd13, OP_SHL = 4'd14, OP_NONE = 4'd15
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_POW_MUL, ST_POW_SQR, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture operands, register the simple-op result
      logic div_step;  // one restoring division step
      logic div_fix;   // apply signs to quotient or remainder
      logic pow_mul;   // acc *= base when exponent bit set
      logic pow_sqr;   // base *= base, exponent >>= 1
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic exp_zero;
   } status_type;
endpackage

[hw/rtl/sia_ctrl.sv]
// controller state machine for the alu
module sia_ctrl
   import sia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  op_type     op,
   input  logic       multi,
   input  status_type status,
   input  logic       rsp_ready,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!multi) state_in = ST_DONE;
               else if (op == OP_POW) state_in = ST_POW_MUL;
               else state_in = ST_DIV;
            end
         end
         ST_DIV: if (status.div_done) state_in = ST_DONE;
         ST_POW_MUL: begin
            if (status.exp_zero) state_in = ST_DONE;
            else state_in = ST_POW_SQR;
         end
         ST_POW_SQR: state_in = ST_POW_MUL;
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         ST_DIV: begin
            cmd.div_step = !status.div_done;
            cmd.div_fix = status.div_done;
         end
         ST_POW_MUL: cmd.pow_mul = !status.exp_zero;
         ST_POW_SQR: cmd.pow_sqr = 1'b1;
         ST_DONE: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end
endmodule

[hw/rtl/sia_datapath.sv]
// operand registers, divider and power unit of the alu
module sia_datapath
   import sia_pkg::*;
#(
   parameter int DATA_WIDTH = DefaultDataWidth
) (
   input  logic                  clock,
   input  cmd_type               cmd,
   input  op_type                op,
   input  logic [DATA_WIDTH-1:0] a,
   input  logic [DATA_WIDTH-1:0] b,
   output status_type            status,
   output logic [DATA_WIDTH-1:0] result,
   output logic                  dbz
);
   localparam int CW = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic                  dbz_ff, dbz_in;
   logic                  is_mod_ff;
   logic                  negq_ff;
   logic [DATA_WIDTH-1:0] quo_ff;   // dividend shifts out, quotient in
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] dvs_ff;
   logic [CW-1:0]         cnt_ff;
   logic [DATA_WIDTH-1:0] base_ff, exp_ff;

   logic                  a_neg, b_neg;
   logic [DATA_WIDTH-1:0] ua, ub, sum, diff, shl_v, shr_v, cat_v, single;
   logic                  slt, sgt;
   logic [DATA_WIDTH:0]   trial_rem, trial_sub;
   logic [DATA_WIDTH-1:0] fixv;
   logic [DATA_WIDTH-1:0] mag_b;

   assign a_neg = a[DATA_WIDTH-1];
   assign b_neg = b[DATA_WIDTH-1];
   assign ua = a_neg ? -a : a;
   assign ub = b_neg ? -b : b;
   assign sum = a + b;
   assign diff = a - b;
   assign slt = $signed(a) < $signed(b);
   assign sgt = $signed(b) < $signed(a);
   assign cat_v = (a << 3) + (a << 1) + b;
   assign mag_b = -b;

   always_comb begin
      if (!b_neg) shl_v = (b >= DATA_WIDTH) ? '0 : a << b;
      else if (mag_b >= DATA_WIDTH || mag_b == '0) shl_v = {DATA_WIDTH{a_neg}};
      else shl_v = DATA_WIDTH'($signed(a) >>> mag_b);
   end
   assign shr_v = shl_v;

   always_comb begin
      single = '0;
      unique case (op)
         OP_ADD: single = sum;
         OP_SUB: single = diff;
         OP_NEG: single = -a;
         OP_MUL: single = a * b;
         OP_LT:  single = DATA_WIDTH'(slt);
         OP_LE:  single = DATA_WIDTH'(!sgt);
         OP_EQ:  single = DATA_WIDTH'(a == b);
         OP_NE:  single = DATA_WIDTH'(a != b);
         OP_GE:  single = DATA_WIDTH'(!slt);
         OP_GT:  single = DATA_WIDTH'(sgt);
         OP_CAT: single = cat_v;
         OP_SHL: single = shr_v;
         default: single = '0;
      endcase
   end

   assign trial_rem = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign trial_sub = trial_rem - {1'b0, dvs_ff};
   assign fixv = is_mod_ff ? rem_ff : quo_ff;

   always_comb begin
      res_in = res_ff;
      dbz_in = dbz_ff;
      if (cmd.load) begin
         dbz_in = 1'b0;
         res_in = single;
         if ((op == OP_DIV || op == OP_MOD) && b == '0) begin
            dbz_in = 1'b1;
            res_in = '0;
         end else if (op == OP_POW) begin
            res_in = b_neg ? '0 : DATA_WIDTH'(1);
         end
      end else if (cmd.div_fix) begin
         res_in = negq_ff ? -fixv : fixv;
      end else if (cmd.pow_mul && exp_ff[0]) begin
         res_in = res_ff * base_ff;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      dbz_ff <= dbz_in;
      if (cmd.load) begin
         is_mod_ff <= (op == OP_MOD);
         negq_ff <= (op == OP_MOD) ? a_neg : (a_neg ^ b_neg);
         quo_ff <= ua;
         rem_ff <= '0;
         dvs_ff <= ub;
         // zero divisor finishes at once
         cnt_ff <= (b == '0) ? CW'(0) : CW'(DATA_WIDTH);
         base_ff <= a;
         exp_ff <= b_neg ? '0 : b;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (!trial_sub[DATA_WIDTH]) begin
            rem_ff <= trial_sub[DATA_WIDTH-1:0];
            quo_ff <= {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= trial_rem[DATA_WIDTH-1:0];
            quo_ff <= {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
      end else if (cmd.pow_sqr) begin
         base_ff <= base_ff * base_ff;
         exp_ff <= exp_ff >> 1;
      end
   end

   // zero divisor: keep result and flag from load
   logic zero_div_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) zero_div_ff <= (b == '0);
   end

   assign status.div_done = (cnt_ff == '0);
   assign status.exp_zero = (exp_ff == '0);
   assign result = (zero_div_ff && dbz_ff) ? '0 : res_ff;
   assign dbz = dbz_ff;
endmodule

[hw/rtl/signed_integer_alu_32.sv]
// signed integer alu top level: one result word per request word
// simple ops and a zero divisor answer from the load; div/mod steps one quotient bit a cycle
//   plus a sign fix, and pow does a multiply and a square per exponent bit
// one word at a time; the next request is taken the cycle after the response is accepted
// reset: synchronous active high, returns the controller to idle, no request taken meanwhile
`include "assert_macros.svh"
module signed_integer_alu_32
   import sia_pkg::*;
#(
   parameter int DATA_WIDTH = DefaultDataWidth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OpWidth-1:0]    req_operation,
   input  logic [DATA_WIDTH-1:0] req_operand_a,
   input  logic [DATA_WIDTH-1:0] req_operand_b,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_result_value,
   output logic                  rsp_divide_by_zero
);
   cmd_type    cmd;
   status_type status;
   logic       busy, start, multi;
   op_type     op;

   assign op = op_type'(req_operation);
   assign req_ready = !busy && !reset;
   assign start = req_valid && req_ready;
   assign multi = ((op == OP_DIV || op == OP_MOD) && req_operand_b != '0) ||
                  (op == OP_POW);

   sia_ctrl u_ctrl (
      .clock, .reset, .start, .op, .multi, .status, .rsp_ready,
      .busy, .rsp_valid, .cmd
   );

   sia_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock, .cmd, .op, .a(req_operand_a), .b(req_operand_b), .status,
      .result(rsp_result_value), .dbz(rsp_divide_by_zero)
   );

   `ASSERT_IMPLIES(a_no_req_while_rsp, clock, reset, rsp_valid, !req_ready)
   `ASSERT_NEXT(a_rsp_after_simple, clock, reset, start && !multi, rsp_valid)
   `ASSERT_IMPLIES(a_flag_zero, clock, reset, rsp_valid && rsp_divide_by_zero, ~|rsp_result_value)
endmodule
